>>> src/vna_pkg.sv
// Shared constants, codes and controller/datapath interface types for the normal averager.
`timescale 1ns / 1ps
package vna_pkg;

  localparam int VNA_VERTS    = 1024;
  localparam int VNA_IDX_W    = $clog2(VNA_VERTS);
  localparam int VNA_POS_W    = 24;
  localparam int VNA_EDGE_W   = VNA_POS_W + 1;
  localparam int VNA_PROD_W   = 2 * VNA_EDGE_W;
  localparam int VNA_CROSS_W  = VNA_PROD_W + 1;
  localparam int VNA_SUM_W    = 64;
  localparam int VNA_CNT_W    = 12;
  localparam int VNA_MAX_FACES = 2048;
  localparam logic [VNA_CNT_W-1:0] VNA_CNT_CAP =
    VNA_CNT_W'((VNA_MAX_FACES < 4095) ? VNA_MAX_FACES : 4095);
  localparam int VNA_NRM_W    = 16;
  localparam int VNA_MAG_W    = 30;
  localparam int VNA_SQ_W     = 2 * VNA_MAG_W + 2;
  localparam int VNA_ROOT_W   = VNA_MAG_W + 1;
  localparam int VNA_FRAC_W   = 15;
  localparam int VNA_NUM_W    = VNA_MAG_W + VNA_FRAC_W + 1;
  localparam int VNA_DIV_STEPS = VNA_NRM_W;
  localparam int VNA_SQRT_STEPS = VNA_SQ_W / 2;
  localparam int VNA_ACC_W    = 3 * VNA_SUM_W + VNA_CNT_W;
  localparam int VNA_STEP_W   = VNA_IDX_W;
  localparam int VNA_IN_DATA_W  = 112;
  localparam int VNA_OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRI   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } vna_op_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CLEAR,
    PH_LOAD,
    PH_RD_POS,
    PH_EDGE,
    PH_MUL,
    PH_ACC_RD,
    PH_ACC_WR,
    PH_Q_RD,
    PH_Q_MAG,
    PH_SHIFT,
    PH_SQ,
    PH_SQRT,
    PH_DIV,
    PH_OUT
  } vna_phase_t;

  typedef struct packed {
    vna_phase_t              phase;
    logic [VNA_STEP_W-1:0]   step;
    logic [1:0]              lane;
  } vna_cmd_t;

  typedef struct packed {
    logic dup_b;
    logic dup_c;
    logic big;
    logic unused;
    logic out_free;
  } vna_sts_t;

endpackage

>>> src/vna_ctrl.sv
// Controller state machine sequencing the clear sweep, loads, triangles and queries.
`timescale 1ns / 1ps
module vna_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  vna_pkg::vna_op_t   in_op,
  output logic               in_tready,
  output vna_pkg::vna_cmd_t  cmd,
  input  vna_pkg::vna_sts_t  sts
);
  import vna_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_RD_POS, S_EDGE, S_MUL, S_ACC_RD, S_ACC_WR,
    S_Q_RD, S_Q_MAG, S_SHIFT, S_SQ, S_SQRT, S_DIV, S_OUT
  } state_t;

  state_t                 state_r;
  logic [VNA_STEP_W-1:0]  cnt_r;
  logic [1:0]             lane_r;
  logic                   skip;

  assign in_tready = (state_r == S_IDLE);
  assign skip = (cnt_r[1:0] == 2'd1 && sts.dup_b) || (cnt_r[1:0] == 2'd2 && sts.dup_c);

  always_comb begin
    cmd.step = cnt_r;
    cmd.lane = lane_r;
    case (state_r)
      S_CLEAR:  cmd.phase = PH_CLEAR;
      S_IDLE:   cmd.phase = PH_IDLE;
      S_LOAD:   cmd.phase = PH_LOAD;
      S_RD_POS: cmd.phase = PH_RD_POS;
      S_EDGE:   cmd.phase = PH_EDGE;
      S_MUL:    cmd.phase = PH_MUL;
      S_ACC_RD: cmd.phase = PH_ACC_RD;
      S_ACC_WR: cmd.phase = PH_ACC_WR;
      S_Q_RD:   cmd.phase = PH_Q_RD;
      S_Q_MAG:  cmd.phase = PH_Q_MAG;
      S_SHIFT:  cmd.phase = PH_SHIFT;
      S_SQ:     cmd.phase = PH_SQ;
      S_SQRT:   cmd.phase = PH_SQRT;
      S_DIV:    cmd.phase = PH_DIV;
      S_OUT:    cmd.phase = PH_OUT;
      default:  cmd.phase = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      lane_r  <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (cnt_r == VNA_STEP_W'(VNA_VERTS - 1)) begin
            state_r <= S_IDLE;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          cnt_r  <= '0;
          lane_r <= '0;
          if (in_tvalid) begin
            case (in_op)
              OP_LOAD:  state_r <= S_LOAD;
              OP_TRI:   state_r <= S_RD_POS;
              OP_QUERY: state_r <= S_Q_RD;
              OP_CLEAR: state_r <= S_CLEAR;
              default:  state_r <= S_IDLE;
            endcase
          end
        end
        S_LOAD: state_r <= S_IDLE;
        S_RD_POS: begin
          if (cnt_r == VNA_STEP_W'(2)) begin
            state_r <= S_EDGE;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_EDGE: state_r <= S_MUL;
        S_MUL: begin
          if (cnt_r == VNA_STEP_W'(6)) begin
            state_r <= S_ACC_RD;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ACC_RD: begin
          if (skip) begin
            if (cnt_r == VNA_STEP_W'(2)) state_r <= S_IDLE;
            else cnt_r <= cnt_r + 1'b1;
          end else begin
            state_r <= S_ACC_WR;
          end
        end
        S_ACC_WR: begin
          if (cnt_r == VNA_STEP_W'(2)) begin
            state_r <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_ACC_RD;
          end
        end
        S_Q_RD: state_r <= S_Q_MAG;
        S_Q_MAG: state_r <= sts.unused ? S_OUT : S_SHIFT;
        S_SHIFT: begin
          if (!sts.big) begin
            state_r <= S_SQ;
            cnt_r   <= '0;
          end
        end
        S_SQ: begin
          if (cnt_r == VNA_STEP_W'(3)) begin
            state_r <= S_SQRT;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SQRT: begin
          if (cnt_r == VNA_STEP_W'(VNA_SQRT_STEPS)) begin
            state_r <= S_DIV;
            cnt_r   <= '0;
            lane_r  <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt_r == VNA_STEP_W'(VNA_DIV_STEPS + 1)) begin
            cnt_r <= '0;
            if (lane_r == 2'd2) state_r <= S_OUT;
            else lane_r <= lane_r + 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_OUT: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/vna_dp.sv
// Datapath: position and accumulator memories, cross product, square root and divider.
`timescale 1ns / 1ps
module vna_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vna_pkg::vna_cmd_t                    cmd,
  output vna_pkg::vna_sts_t                    sts,
  input  logic                                 in_tvalid,
  input  logic [vna_pkg::VNA_IN_DATA_W-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [vna_pkg::VNA_OUT_DATA_W-1:0]   out_tdata,
  output logic                                 out_tuser
);
  import vna_pkg::*;

  localparam int PW = 3 * VNA_POS_W;

  logic [VNA_IDX_W-1:0] vi_r, ca_r, cb_r, cc_r;
  logic [PW-1:0]        pos_in_r;
  logic [PW-1:0]        pos_mem [VNA_VERTS];
  logic [PW-1:0]        pos_rd_r, pa_r, pb_r;
  logic [VNA_IDX_W-1:0] pos_raddr;

  logic signed [VNA_EDGE_W-1:0]  e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [VNA_EDGE_W-1:0]  mul_a, mul_b;
  logic signed [VNA_PROD_W-1:0]  prod_r;
  logic signed [VNA_CROSS_W-1:0] cx_r, cy_r, cz_r;

  logic [VNA_ACC_W-1:0]  acc_mem [VNA_VERTS];
  logic [VNA_ACC_W-1:0]  acc_rd_r, acc_wdata;
  logic [VNA_IDX_W-1:0]  acc_raddr, acc_waddr, corner;
  logic                  acc_we;
  logic [VNA_SUM_W-1:0]  rsx, rsy, rsz;
  logic [VNA_CNT_W-1:0]  rcnt, ncnt;

  logic [VNA_SUM_W-1:0]  ax_r, ay_r, az_r;
  logic                  nx_r, ny_r, nz_r;
  logic [VNA_CNT_W-1:0]  qcnt_r;
  logic                  unused_r;
  logic [VNA_MAG_W-1:0]  sq_in;
  logic [2*VNA_MAG_W-1:0] sq_prod_r;
  logic [VNA_SQ_W-1:0]   sqsum_r, sv_r, sres_r, sbit_r, strial;
  logic [VNA_ROOT_W-1:0] root;
  logic [VNA_MAG_W-1:0]  div_a;
  logic                  div_neg;
  logic [VNA_NUM_W-1:0]  rem_r, dvs_r;
  logic [VNA_NRM_W-1:0]  q_r, qsat;
  logic [VNA_NRM_W-1:0]  nrmx_r, nrmy_r, nrmz_r;
  logic                  out_valid_r;
  logic [VNA_OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  // position store
  always_comb begin
    case (cmd.step[1:0])
      2'd0:    pos_raddr = ca_r;
      2'd1:    pos_raddr = cb_r;
      default: pos_raddr = cc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.phase == PH_LOAD) pos_mem[vi_r] <= pos_in_r;
    pos_rd_r <= pos_mem[pos_raddr];
  end

  // capture transaction
  always_ff @(posedge clk) begin
    if (cmd.phase == PH_IDLE && in_tvalid) begin
      vi_r     <= in_tdata[9:0];
      pos_in_r <= {in_tdata[81:58], in_tdata[57:34], in_tdata[33:10]};
      ca_r     <= in_tdata[91:82];
      cb_r     <= in_tdata[101:92];
      cc_r     <= in_tdata[111:102];
    end
  end

  // edges and cross product
  always_comb begin
    case (cmd.step[2:0])
      3'd0:    begin mul_a = e1y_r; mul_b = e2z_r; end
      3'd1:    begin mul_a = e1z_r; mul_b = e2y_r; end
      3'd2:    begin mul_a = e1z_r; mul_b = e2x_r; end
      3'd3:    begin mul_a = e1x_r; mul_b = e2z_r; end
      3'd4:    begin mul_a = e1x_r; mul_b = e2y_r; end
      default: begin mul_a = e1y_r; mul_b = e2x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.phase == PH_RD_POS && cmd.step[1:0] == 2'd1) pa_r <= pos_rd_r;
    if (cmd.phase == PH_RD_POS && cmd.step[1:0] == 2'd2) pb_r <= pos_rd_r;
    if (cmd.phase == PH_EDGE) begin
      e1x_r <= VNA_EDGE_W'(signed'(pa_r[23:0]))  - VNA_EDGE_W'(signed'(pos_rd_r[23:0]));
      e1y_r <= VNA_EDGE_W'(signed'(pa_r[47:24])) - VNA_EDGE_W'(signed'(pos_rd_r[47:24]));
      e1z_r <= VNA_EDGE_W'(signed'(pa_r[71:48])) - VNA_EDGE_W'(signed'(pos_rd_r[71:48]));
      e2x_r <= VNA_EDGE_W'(signed'(pa_r[23:0]))  - VNA_EDGE_W'(signed'(pb_r[23:0]));
      e2y_r <= VNA_EDGE_W'(signed'(pa_r[47:24])) - VNA_EDGE_W'(signed'(pb_r[47:24]));
      e2z_r <= VNA_EDGE_W'(signed'(pa_r[71:48])) - VNA_EDGE_W'(signed'(pb_r[71:48]));
    end
    if (cmd.phase == PH_MUL) begin
      prod_r <= mul_a * mul_b;
      case (cmd.step[2:0])
        3'd1:    cx_r <= VNA_CROSS_W'(prod_r);
        3'd2:    cx_r <= cx_r - VNA_CROSS_W'(prod_r);
        3'd3:    cy_r <= VNA_CROSS_W'(prod_r);
        3'd4:    cy_r <= cy_r - VNA_CROSS_W'(prod_r);
        3'd5:    cz_r <= VNA_CROSS_W'(prod_r);
        3'd6:    cz_r <= cz_r - VNA_CROSS_W'(prod_r);
        default: ;
      endcase
    end
  end

  // accumulator store
  assign corner = pos_raddr;
  assign rsx  = acc_rd_r[VNA_SUM_W-1:0];
  assign rsy  = acc_rd_r[2*VNA_SUM_W-1:VNA_SUM_W];
  assign rsz  = acc_rd_r[3*VNA_SUM_W-1:2*VNA_SUM_W];
  assign rcnt = acc_rd_r[VNA_ACC_W-1:3*VNA_SUM_W];
  assign ncnt = (rcnt < VNA_CNT_CAP) ? rcnt + 1'b1 : rcnt;
  assign acc_raddr = (cmd.phase == PH_Q_RD) ? vi_r : corner;

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = corner;
    acc_wdata = '0;
    if (cmd.phase == PH_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = cmd.step[VNA_IDX_W-1:0];
    end else if (cmd.phase == PH_ACC_WR) begin
      acc_we    = 1'b1;
      acc_wdata = {ncnt,
                   rsz + VNA_SUM_W'(cz_r),
                   rsy + VNA_SUM_W'(cy_r),
                   rsx + VNA_SUM_W'(cx_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd_r <= acc_mem[acc_raddr];
  end

  // magnitude, shift, squares, root, divide
  always_comb begin
    case (cmd.step[1:0])
      2'd0:    sq_in = ax_r[VNA_MAG_W-1:0];
      2'd1:    sq_in = ay_r[VNA_MAG_W-1:0];
      default: sq_in = az_r[VNA_MAG_W-1:0];
    endcase
    case (cmd.lane)
      2'd0:    begin div_a = ax_r[VNA_MAG_W-1:0]; div_neg = nx_r; end
      2'd1:    begin div_a = ay_r[VNA_MAG_W-1:0]; div_neg = ny_r; end
      default: begin div_a = az_r[VNA_MAG_W-1:0]; div_neg = nz_r; end
    endcase
  end

  assign strial = sres_r + sbit_r;
  assign root   = sres_r[VNA_ROOT_W-1:0];
  assign qsat   = div_neg ? (VNA_NRM_W'(0) - q_r) :
                  (q_r[VNA_NRM_W-1] ? {1'b0, {(VNA_NRM_W-1){1'b1}}} : q_r);

  always_ff @(posedge clk) begin
    case (cmd.phase)
      PH_Q_MAG: begin
        nx_r     <= rsx[VNA_SUM_W-1];
        ny_r     <= rsy[VNA_SUM_W-1];
        nz_r     <= rsz[VNA_SUM_W-1];
        ax_r     <= rsx[VNA_SUM_W-1] ? (~rsx + 1'b1) : rsx;
        ay_r     <= rsy[VNA_SUM_W-1] ? (~rsy + 1'b1) : rsy;
        az_r     <= rsz[VNA_SUM_W-1] ? (~rsz + 1'b1) : rsz;
        qcnt_r   <= rcnt;
        unused_r <= (rcnt == '0);
        nrmx_r   <= '0;
        nrmy_r   <= '0;
        nrmz_r   <= '0;
      end
      PH_SHIFT: begin
        if (sts.big) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
          az_r <= az_r >> 1;
        end
      end
      PH_SQ: begin
        sq_prod_r <= sq_in * sq_in;
        if (cmd.step[1:0] == 2'd0) sqsum_r <= '0;
        else sqsum_r <= sqsum_r + VNA_SQ_W'(sq_prod_r);
      end
      PH_SQRT: begin
        if (cmd.step == '0) begin
          sv_r   <= sqsum_r;
          sres_r <= '0;
          sbit_r <= VNA_SQ_W'(1) << (VNA_SQ_W - 2);
        end else begin
          if (sv_r >= strial) begin
            sv_r   <= sv_r - strial;
            sres_r <= (sres_r >> 1) + sbit_r;
          end else begin
            sres_r <= sres_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
        end
      end
      PH_DIV: begin
        if (cmd.step == '0) begin
          rem_r <= {1'b0, div_a, VNA_FRAC_W'(0)} + VNA_NUM_W'(root >> 1);
          dvs_r <= VNA_NUM_W'(root) << VNA_FRAC_W;
          q_r   <= '0;
        end else if (cmd.step == VNA_STEP_W'(VNA_DIV_STEPS + 1)) begin
          if (root != '0) begin
            case (cmd.lane)
              2'd0:    nrmx_r <= qsat;
              2'd1:    nrmy_r <= qsat;
              default: nrmz_r <= qsat;
            endcase
          end
        end else begin
          if (rem_r >= dvs_r) begin
            rem_r <= rem_r - dvs_r;
            q_r   <= {q_r[VNA_NRM_W-2:0], 1'b1};
          end else begin
            q_r <= {q_r[VNA_NRM_W-2:0], 1'b0};
          end
          dvs_r <= dvs_r >> 1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.phase == PH_OUT && !out_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.phase == PH_OUT && !out_valid_r) begin
      out_data_r <= {2'b00, qcnt_r, nrmz_r, nrmy_r, nrmx_r, vi_r};
      out_user_r <= unused_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign sts.dup_b    = (cb_r == ca_r);
  assign sts.dup_c    = (cc_r == ca_r) || (cc_r == cb_r);
  assign sts.big      = (|ax_r[VNA_SUM_W-1:VNA_MAG_W]) || (|ay_r[VNA_SUM_W-1:VNA_MAG_W]) ||
                        (|az_r[VNA_SUM_W-1:VNA_MAG_W]);
  assign sts.unused   = (rcnt == '0);
  assign sts.out_free = !out_valid_r;

endmodule

>>> src/vertex_normal_averager.sv
// Top level of the smoothed vertex normal averager.
`timescale 1ns / 1ps
// Loads signed Q8.16 vertex positions, adds each triangle's cross-product face normal
// to the sums of its distinct corners, and answers queries with the normalized sum as
// Q1.15 plus the face count. A triangle takes three position reads, six products
// through one multiplier and one read-modify-write per distinct corner. A query of a
// vertex that no face uses skips the scaling, square root and divisions; any other query
// runs up to 34 one-bit scaling shifts, the 31-step square root and three 16-step
// divisions. A query also holds while an earlier result still waits in the output
// register. After reset and after every clear transaction the accumulator memory is
// swept to zero, and no transaction is accepted during the sweep. A result waits in
// an output register, so the next transaction is taken while it is pending.
module vertex_normal_averager (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
  input  logic [111:0]  in_tdata,
  // op
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // out_index, normal_x, normal_y, normal_z, faces_using, zero pad
  output logic [71:0]   out_tdata,
  // unused_vertex
  output logic          out_tuser
);
  import vna_pkg::*;

  vna_cmd_t cmd;
  vna_sts_t sts;

  vna_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (vna_op_t'(in_tuser)),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  vna_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> src/vna_checker.sv
// Port-level checker for the normal averager, bound to the top level.
`timescale 1ns / 1ps
module vna_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [71:0]  out_tdata,
  input logic         out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[69:10] == 60'd0)
    else $error("unused vertex with nonzero normal or count");

  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[69:58] != 12'd0 && out_tdata[69:58] <= 12'd2048)
    else $error("used vertex with bad face count");

endmodule

bind vertex_normal_averager vna_checker u_vna_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
